// File: src/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// shared types, widths and codes of the ordered list engine
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OP_W     = 4;
  localparam int POS_W    = 8;
  localparam int ECNT_W   = 7;
  localparam int ST_W     = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK    = 4'd1;
  localparam logic [OP_W-1:0] OP_INSERT_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT    = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK     = 4'd4;
  localparam logic [OP_W-1:0] OP_DELETE_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_DELETE_VALUE = 4'd6;
  localparam logic [OP_W-1:0] OP_CLEAR        = 4'd7;
  localparam logic [OP_W-1:0] OP_DUMP         = 4'd8;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] entry_value;
    logic                    last_of_run;
    logic [ECNT_W-1:0]       entry_count;
    logic [ST_W-1:0]         status;
  } out_t;

  // source of a cell's next value
  typedef enum logic [2:0] {
    SEL_HOLD  = 3'd0,
    SEL_LOAD  = 3'd1,
    SEL_LEFT  = 3'd2,
    SEL_RIGHT = 3'd3,
    SEL_HEAD  = 3'd4
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t               sel;
    logic signed [VAL_W-1:0] new_value;
    logic signed [VAL_W-1:0] key;
  } cell_ctrl_t;

endpackage

// File: src/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell
// one list slot: holds a value, loads a new one or the head's, shifts from a neighbor and compares to a key
// ----------------------------------------------------------------------------
module olist_cell (
  input  logic                                 clk,
  input  olist_pkg::cell_ctrl_t                ctrl,
  input  logic signed [olist_pkg::VAL_W-1:0]   left_in,
  input  logic signed [olist_pkg::VAL_W-1:0]   right_in,
  input  logic signed [olist_pkg::VAL_W-1:0]   head_in,
  output logic signed [olist_pkg::VAL_W-1:0]   value_out,
  output logic                                 match_out
);

  logic signed [olist_pkg::VAL_W-1:0] value_r;
  logic signed [olist_pkg::VAL_W-1:0] value_nxt;

  always_comb begin
    case (ctrl.sel)
      olist_pkg::SEL_LOAD:  value_nxt = ctrl.new_value;
      olist_pkg::SEL_LEFT:  value_nxt = left_in;
      olist_pkg::SEL_RIGHT: value_nxt = right_in;
      olist_pkg::SEL_HEAD:  value_nxt = head_in;
      default:              value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_out = value_r;
  assign match_out = (value_r == ctrl.key);

endmodule

// File: src/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// ordered list of signed values kept in a row of shifting cells
// ----------------------------------------------------------------------------
// usage
//   input word: in_data (operation, item_value, position), taken at a rising
//   edge with start high and busy low
//   result word: out_data, shown for exactly one cycle with out_valid high;
//   the receiver cannot stall, so no back pressure exists
// timing
//   a command is registered on accept and executed in the next cycle; its
//   result, a single word unless it starts a dump, appears in the cycle after;
//   busy is high while it executes, and no new command is taken before idle
//   dump: an empty list gives a single missing word; otherwise one result
//   word per stored entry follows, and the chain rotates left once per word so
//   cell 0 always holds the next entry; after count rotations it is back in order
//   an insert or remove shifts the cells from its target slot up in the
//   execute cycle; delete-by-value compares all cells at once, first hit wins
// reset
//   rst_n (synchronous, active low) empties the list and idles the output;
//   cell contents are not cleared, only the entry count
// ----------------------------------------------------------------------------
module ordered_list_engine_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  olist_pkg::in_t    in_data,
  output logic              out_valid,
  output olist_pkg::out_t   out_data
);

  localparam int N = olist_pkg::CAPACITY;
  localparam int CW = olist_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  olist_pkg::in_t  cmd_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   dump_idx_r, dump_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  olist_pkg::out_t out_r, out_nxt;

  // cell chain
  olist_pkg::cell_ctrl_t                ctrl    [N];
  logic signed [olist_pkg::VAL_W-1:0]   cell_val[N];
  logic [N-1:0]                         match;

  // execute-cycle decode
  logic                    full;
  logic [olist_pkg::POS_W-1:0] count_pos;
  logic                    pos_ok;
  logic [CW-1:0]           pos_idx;
  logic                    found;
  logic [CW-1:0]           found_idx;
  logic                    do_ins, do_rem, do_rot;
  logic [CW-1:0]           tgt_idx;
  logic [olist_pkg::ST_W-1:0] status;
  logic [CW-1:0]           last_idx;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign full      = (count_r == CW'(N));
  assign count_pos = olist_pkg::POS_W'(count_r);
  assign pos_ok    = (cmd_r.position != '0) && (cmd_r.position <= count_pos);
  assign pos_idx   = CW'(cmd_r.position - 1'b1);
  assign last_idx  = count_r - 1'b1;

  // first matching cell within the live part of the list
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i] && (CW'(i) < count_r)) begin
        found     = 1'b1;
        found_idx = CW'(i);
      end
    end
  end

  // command decode and control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dump_idx_nxt  = dump_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    do_ins        = 1'b0;
    do_rem        = 1'b0;
    do_rot        = 1'b0;
    tgt_idx       = '0;
    status        = olist_pkg::ST_DONE;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        case (cmd_r.operation)
          olist_pkg::OP_PUSH_FRONT: begin
            tgt_idx = '0;
            do_ins  = !full;
          end
          olist_pkg::OP_PUSH_BACK: begin
            tgt_idx = count_r;
            do_ins  = !full;
          end
          olist_pkg::OP_INSERT_AT: begin
            tgt_idx = pos_ok ? pos_idx : count_r;
            do_ins  = !full;
          end
          olist_pkg::OP_POP_FRONT: begin
            tgt_idx = '0;
            do_rem  = (count_r != '0);
          end
          olist_pkg::OP_POP_BACK: begin
            tgt_idx = last_idx;
            do_rem  = (count_r != '0);
          end
          olist_pkg::OP_DELETE_AT: begin
            tgt_idx = pos_idx;
            do_rem  = pos_ok;
          end
          olist_pkg::OP_DELETE_VALUE: begin
            tgt_idx = found_idx;
            do_rem  = found;
          end
          olist_pkg::OP_CLEAR: begin
            count_nxt = '0;
          end
          olist_pkg::OP_DUMP: begin
            if (count_r == '0) begin
              status = olist_pkg::ST_MISSING;
            end else begin
              state_nxt    = S_DUMP;
              dump_idx_nxt = '0;
            end
          end
          default: begin
            status = olist_pkg::ST_DONE;
          end
        endcase

        // insert and remove both report through the common path
        if ((cmd_r.operation == olist_pkg::OP_PUSH_FRONT) ||
            (cmd_r.operation == olist_pkg::OP_PUSH_BACK)  ||
            (cmd_r.operation == olist_pkg::OP_INSERT_AT)) begin
          if (full) status = olist_pkg::ST_FULL;
          else      count_nxt = count_r + 1'b1;
        end
        if ((cmd_r.operation == olist_pkg::OP_POP_FRONT)    ||
            (cmd_r.operation == olist_pkg::OP_POP_BACK)     ||
            (cmd_r.operation == olist_pkg::OP_DELETE_AT)    ||
            (cmd_r.operation == olist_pkg::OP_DELETE_VALUE)) begin
          if (do_rem) count_nxt = count_r - 1'b1;
          else        status    = olist_pkg::ST_MISSING;
        end

        if (state_nxt == S_IDLE) begin
          out_valid_nxt       = 1'b1;
          out_nxt.entry_value = '0;
          out_nxt.last_of_run = 1'b1;
          out_nxt.entry_count = olist_pkg::ECNT_W'(count_nxt);
          out_nxt.status      = status;
        end
      end

      S_DUMP: begin
        // cell 0 holds the next entry; rotate it to the tail
        do_rot              = 1'b1;
        out_valid_nxt       = 1'b1;
        out_nxt.entry_value = cell_val[0];
        out_nxt.last_of_run = (dump_idx_r == last_idx);
        out_nxt.entry_count = olist_pkg::ECNT_W'(count_r);
        out_nxt.status      = olist_pkg::ST_DONE;
        dump_idx_nxt        = dump_idx_r + 1'b1;
        if (dump_idx_r == last_idx) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // per-cell source select
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctrl[i].new_value = cmd_r.item_value;
      ctrl[i].key       = cmd_r.item_value;
      ctrl[i].sel       = olist_pkg::SEL_HOLD;
      if (do_ins) begin
        if (CW'(i) > tgt_idx)       ctrl[i].sel = olist_pkg::SEL_LEFT;
        else if (CW'(i) == tgt_idx) ctrl[i].sel = olist_pkg::SEL_LOAD;
      end else if (do_rem) begin
        if (CW'(i) >= tgt_idx) ctrl[i].sel = olist_pkg::SEL_RIGHT;
      end else if (do_rot) begin
        if (CW'(i) < last_idx)       ctrl[i].sel = olist_pkg::SEL_RIGHT;
        else if (CW'(i) == last_idx) ctrl[i].sel = olist_pkg::SEL_HEAD;
      end
    end
  end

  // the chain itself
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [olist_pkg::VAL_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_val[g];
    end else begin : g_mid_l
      assign left_w = cell_val[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_w = cell_val[g];
    end else begin : g_mid_r
      assign right_w = cell_val[g+1];
    end

    olist_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .left_in   (left_w),
      .right_in  (right_w),
      .head_in   (cell_val[0]),
      .value_out (cell_val[g]),
      .match_out (match[g])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (start && !busy) begin
      cmd_r <= in_data;
    end
  end

endmodule

// File: tb/sv/tb_ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_unit
// self-checking testbench for the ordered list engine
// ----------------------------------------------------------------------------
// A behavioral copy of the list is kept in the testbench. Every accepted
// command word updates that copy and queues the result words it must cause.
// A monitor compares each strobed result word, field by field, against the
// oldest queued word. Stimulus is a directed pass over the corner cases
// (empty list, insert positions, removals, unknown codes, full list),
// followed by random fill and drain rounds and a back-to-back burst.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // codes with no operation behind them
  localparam logic [olist_pkg::OP_W-1:0] OP_FIRST_UNUSED = 4'd9;
  localparam logic [olist_pkg::OP_W-1:0] OP_LAST_UNUSED  = 4'd15;

  // stimulus mix for the random part
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  localparam int RESET_CYCLES = 12;
  localparam int TAIL_CYCLES  = 2 * olist_pkg::CAPACITY + 8;
  localparam int DRAIN_LIMIT  = 2000;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            start;
  logic            busy;
  olist_pkg::in_t  in_data;
  logic            out_valid;
  olist_pkg::out_t out_data;

  // shadow copy of the list held by the block
  logic signed [olist_pkg::VAL_W-1:0] list_vals [olist_pkg::CAPACITY];
  int                                 list_len;

  // result words still to come, oldest first
  olist_pkg::out_t pending_results [$];

  int  err_count;
  int  result_idx;
  bit  idle_en;

  ordered_list_engine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // list predictor
  // --------------------------------------------------------------------------
  function automatic void flag_error(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void queue_result(logic signed [olist_pkg::VAL_W-1:0] v, logic last,
                                       logic [olist_pkg::ST_W-1:0] st);
    olist_pkg::out_t r;
    r.entry_value = v;
    r.last_of_run = last;
    r.entry_count = olist_pkg::ECNT_W'(list_len);
    r.status      = st;
    pending_results.push_back(r);
  endfunction

  // place v so that it becomes element idx (0-based); past the end appends
  function automatic logic [olist_pkg::ST_W-1:0] list_insert(
    int idx, logic signed [olist_pkg::VAL_W-1:0] v);
    int i;
    if (list_len >= olist_pkg::CAPACITY) begin
      return olist_pkg::ST_FULL;
    end
    if (idx > list_len) begin
      idx = list_len;
    end
    for (i = list_len; i > idx; i--) begin
      list_vals[i] = list_vals[i-1];
    end
    list_vals[idx] = v;
    list_len++;
    return olist_pkg::ST_DONE;
  endfunction

  function automatic logic [olist_pkg::ST_W-1:0] list_remove(int idx);
    int i;
    if (idx < 0 || idx >= list_len) begin
      return olist_pkg::ST_MISSING;
    end
    for (i = idx; i + 1 < list_len; i++) begin
      list_vals[i] = list_vals[i+1];
    end
    list_len--;
    return olist_pkg::ST_DONE;
  endfunction

  function automatic void predict_list_op(olist_pkg::in_t w);
    logic [olist_pkg::ST_W-1:0] st;
    int                         i;
    st = olist_pkg::ST_DONE;
    case (w.operation)
      olist_pkg::OP_PUSH_FRONT: st = list_insert(0, w.item_value);
      olist_pkg::OP_PUSH_BACK:  st = list_insert(list_len, w.item_value);
      olist_pkg::OP_INSERT_AT: begin
        // position zero or past the end appends
        if (w.position == 0 || int'(w.position) > list_len) begin
          st = list_insert(list_len, w.item_value);
        end else begin
          st = list_insert(int'(w.position) - 1, w.item_value);
        end
      end
      olist_pkg::OP_POP_FRONT: st = list_remove(0);
      olist_pkg::OP_POP_BACK:  st = list_remove(list_len - 1);
      olist_pkg::OP_DELETE_AT: begin
        if (w.position == 0) begin
          st = olist_pkg::ST_MISSING;
        end else begin
          st = list_remove(int'(w.position) - 1);
        end
      end
      olist_pkg::OP_DELETE_VALUE: begin
        // first match only
        st = olist_pkg::ST_MISSING;
        for (i = 0; i < list_len; i++) begin
          if (list_vals[i] == w.item_value) begin
            st = list_remove(i);
            break;
          end
        end
      end
      olist_pkg::OP_CLEAR: list_len = 0;
      olist_pkg::OP_DUMP: begin
        if (list_len == 0) begin
          queue_result('0, 1'b1, olist_pkg::ST_MISSING);
        end else begin
          for (i = 0; i < list_len; i++) begin
            queue_result(list_vals[i], (i == list_len - 1), olist_pkg::ST_DONE);
          end
        end
        return;
      end
      default: st = olist_pkg::ST_DONE;
    endcase
    queue_result('0, 1'b1, st);
  endfunction

  // --------------------------------------------------------------------------
  // command driver
  // --------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_en) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // drive one command word and hold it until the block takes it
  task automatic send_cmd(logic [olist_pkg::OP_W-1:0] op,
                          logic signed [olist_pkg::VAL_W-1:0] v,
                          logic [olist_pkg::POS_W-1:0] pos);
    olist_pkg::in_t w;
    int             gap;
    w.operation  = op;
    w.item_value = v;
    w.position   = pos;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    forever begin
      @(posedge clk);
      if (!busy) begin
        break;
      end
    end
    predict_list_op(w);
  endtask

  // values: stored entries (so deletes hit), a small pool for duplicates,
  // the extremes, or anything
  function automatic logic signed [olist_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3 && list_len > 0) begin
      return list_vals[$urandom_range(0, list_len - 1)];
    end else if (r < 5) begin
      return olist_pkg::VAL_W'($signed($urandom_range(0, 6)) - 3);
    end else if (r == 5) begin
      return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
    end
    return $signed($urandom);
  endfunction

  // positions: mostly inside or just past the list, some anywhere
  function automatic logic [olist_pkg::POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return olist_pkg::POS_W'($urandom_range(0, 255));
    end
    return olist_pkg::POS_W'($urandom_range(1, list_len + 1));
  endfunction

  function automatic logic [olist_pkg::OP_W-1:0] pick_op(int mix);
    int r;
    int ins_w;
    r = $urandom_range(0, 99);
    ins_w = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 20 : 45;
    if (r < ins_w) begin
      case ($urandom_range(0, 2))
        0:       return olist_pkg::OP_PUSH_FRONT;
        1:       return olist_pkg::OP_PUSH_BACK;
        default: return olist_pkg::OP_INSERT_AT;
      endcase
    end else if (r < 91) begin
      case ($urandom_range(0, 3))
        0:       return olist_pkg::OP_POP_FRONT;
        1:       return olist_pkg::OP_POP_BACK;
        2:       return olist_pkg::OP_DELETE_AT;
        default: return olist_pkg::OP_DELETE_VALUE;
      endcase
    end else if (r < 96) begin
      return olist_pkg::OP_DUMP;
    end else if (r < 98) begin
      return olist_pkg::OP_CLEAR;
    end
    return olist_pkg::OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
  endfunction

  task automatic send_random(int mix);
    send_cmd(pick_op(mix), pick_value(), pick_position());
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // every removal and a dump on a freshly reset list
  task automatic test_empty_list();
    send_cmd(olist_pkg::OP_DUMP, '0, '0);
    send_cmd(olist_pkg::OP_POP_FRONT, '0, '0);
    send_cmd(olist_pkg::OP_POP_BACK, '0, '0);
    send_cmd(olist_pkg::OP_DELETE_AT, '0, 8'd1);
    send_cmd(olist_pkg::OP_DELETE_VALUE, '0, '0);
  endtask

  // front, back, position zero, past the end, head and middle inserts
  task automatic test_insert_positions();
    send_cmd(olist_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff, '0);
    send_cmd(olist_pkg::OP_PUSH_BACK, 32'sh8000_0000, 8'hff);
    send_cmd(olist_pkg::OP_INSERT_AT, -32'sd1, '0);
    send_cmd(olist_pkg::OP_INSERT_AT, 32'sd0, 8'hff);
    send_cmd(olist_pkg::OP_INSERT_AT, 32'sd1, 8'd1);
    send_cmd(olist_pkg::OP_INSERT_AT, 32'sd5, 8'd3);
    send_cmd(olist_pkg::OP_PUSH_BACK, -32'sd1, '0);
    send_cmd(olist_pkg::OP_DUMP, '0, '0);
  endtask

  // duplicate value, missing value, missing positions and a valid one, then ordinary pops
  task automatic test_removals();
    send_cmd(olist_pkg::OP_DELETE_VALUE, -32'sd1, '0);
    send_cmd(olist_pkg::OP_DELETE_VALUE, 32'sd12345, '0);
    send_cmd(olist_pkg::OP_DELETE_AT, '0, '0);
    send_cmd(olist_pkg::OP_DELETE_AT, '0, 8'hff);
    send_cmd(olist_pkg::OP_DELETE_AT, '0, 8'd2);
    send_cmd(olist_pkg::OP_POP_FRONT, '0, '0);
    send_cmd(olist_pkg::OP_POP_BACK, '0, '0);
  endtask

  // unused codes leave the list alone, clear empties it
  task automatic test_unknown_and_clear();
    send_cmd(OP_FIRST_UNUSED, 32'sh7fff_ffff, 8'hff);
    send_cmd(OP_LAST_UNUSED, 32'sh8000_0000, '0);
    send_cmd(olist_pkg::OP_DUMP, '0, '0);
    send_cmd(olist_pkg::OP_CLEAR, '0, '0);
    send_cmd(olist_pkg::OP_DUMP, '0, '0);
  endtask

  // fill to capacity, every insert kind is refused, full dump, then delete the last entry and one by value
  task automatic test_capacity_limit();
    send_cmd(olist_pkg::OP_CLEAR, '0, '0);
    while (list_len < olist_pkg::CAPACITY) begin
      send_cmd(($urandom_range(0, 1) != 0) ? olist_pkg::OP_PUSH_BACK : olist_pkg::OP_INSERT_AT,
               pick_value(), pick_position());
    end
    send_cmd(olist_pkg::OP_PUSH_FRONT, pick_value(), '0);
    send_cmd(olist_pkg::OP_PUSH_BACK, pick_value(), '0);
    send_cmd(olist_pkg::OP_INSERT_AT, pick_value(), 8'd1);
    send_cmd(olist_pkg::OP_DUMP, '0, '0);
    send_cmd(olist_pkg::OP_DELETE_AT, '0, olist_pkg::POS_W'(olist_pkg::CAPACITY));
    send_cmd(olist_pkg::OP_DELETE_VALUE, list_vals[0], '0);
  endtask

  // rounds that grow the list toward full, then shrink it toward empty
  task automatic test_fill_drain_rounds();
    int round;
    for (round = 0; round < 4; round++) begin
      repeat (42) send_random(MIX_FILL);
      repeat (42) send_random(MIX_DRAIN);
    end
  endtask

  // commands at the full rate with no idle cycles
  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (40) send_random(MIX_EVEN);
    idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    olist_pkg::out_t exp_w;
    string           diff;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf({"result word %0d with nothing expected: ",
                              "value=%0d last=%0b count=%0d status=%0d"},
                             result_idx, out_data.entry_value, out_data.last_of_run,
                             out_data.entry_count, out_data.status));
      end else begin
        exp_w = pending_results.pop_front();
        diff  = "";
        if (out_data.entry_value !== exp_w.entry_value) diff = {diff, " entry_value"};
        if (out_data.last_of_run !== exp_w.last_of_run) diff = {diff, " last_of_run"};
        if (out_data.entry_count !== exp_w.entry_count) diff = {diff, " entry_count"};
        if (out_data.status !== exp_w.status)           diff = {diff, " status"};
        if (diff != "") begin
          flag_error($sformatf({"result word %0d bad%s: expected value=%0d last=%0b ",
                                "count=%0d status=%0d, got value=%0d last=%0b ",
                                "count=%0d status=%0d"},
                               result_idx, diff, exp_w.entry_value, exp_w.last_of_run,
                               exp_w.entry_count, exp_w.status, out_data.entry_value,
                               out_data.last_of_run, out_data.entry_count, out_data.status));
        end
      end
      result_idx++;
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int waited;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    list_len   = 0;
    err_count  = 0;
    result_idx = 0;
    idle_en    = 1'b1;
    foreach (list_vals[i]) list_vals[i] = '0;

    // single synchronous reset at the start of the run
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_insert_positions();
    test_removals();
    test_unknown_and_clear();
    test_capacity_limit();
    test_fill_drain_rounds();
    test_back_to_back();

    @(negedge clk) start <= 1'b0;

    // let every queued result word arrive, then watch a quiet tail
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d result words never arrived", pending_results.size()));
    end

    if (err_count == 0) begin
      $display("ordered_list_engine_unit test passed");
    end else begin
      $display("ordered_list_engine_unit test failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("ordered_list_engine_unit test failed");
    $finish;
  end

endmodule
